// ===== rtl/pidh_pkg.sv =====
// ============================================================================
// pidh_pkg: shared types and constants of the PID heater duty controller
// Field widths, register indexes and fixed-point settings used by the datapath.
// ============================================================================
package pidh_pkg;

    // Fixed-point setup: all temperatures and gains carry FRACTION_BITS bits.
    localparam int FRACTION_BITS    = 8;
    localparam int DRIVE_FULL_SCALE = 1024;

    // Field widths
    localparam int TEMP_W   = 16;                 // sample, setpoint, gains
    localparam int ERR_W    = TEMP_W + 1;         // setpoint - sample, sample change
    localparam int SUM_W    = 18;                 // clamped error sum
    localparam int LIMIT_W  = 17;                 // windup limit magnitude
    localparam int DUTY_W   = 8;
    localparam int PROD_PE_W = TEMP_W + ERR_W;    // gain * error
    localparam int PROD_I_W  = TEMP_W + SUM_W;    // gain * error sum
    localparam int DRIVE_W   = PROD_I_W + 2;      // sum of three products

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LIMIT_W;

    // Duty ceiling and the compare value of a switched-off relay
    localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

    localparam logic [LIMIT_W-1:0] WINDUP_RESET = 17'h1FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT   = 3'd0,
        REG_PROP_GAIN  = 3'd1,
        REG_INTEG_GAIN = 3'd2,
        REG_DERIV_GAIN = 3'd3,
        REG_WINDUP     = 3'd4
    } t_cfg_reg;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_CLEAR = 1'b1
    } t_op;

endpackage

// ===== rtl/pidh_output_map.sv =====
// ============================================================================
// pidh_output_map: drive value to duty and relay compare
// Cut the Q.2F drive to an integer, clamp to zero and full scale, divide by four.
// ============================================================================
module pidh_output_map (
    input  logic signed [pidh_pkg::DRIVE_W-1:0] i_drive,
    output logic        [pidh_pkg::DUTY_W-1:0]  o_duty,
    output logic        [pidh_pkg::DUTY_W-1:0]  o_pwm_compare
);

    localparam int DRIVE_W   = pidh_pkg::DRIVE_W;
    localparam int DUTY_W    = pidh_pkg::DUTY_W;
    localparam int LEVEL_W   = $clog2(pidh_pkg::DRIVE_FULL_SCALE);
    localparam int LEVEL_MAX = pidh_pkg::DRIVE_FULL_SCALE - 1;
    localparam int QUART_W   = (LEVEL_W > DUTY_W + 2) ? LEVEL_W - 2 : DUTY_W;

    logic signed [DRIVE_W-1:0] shifted;
    logic        [LEVEL_W-1:0] level;
    logic        [QUART_W-1:0] quarter;

    always_comb begin
        shifted = i_drive >>> (2 * pidh_pkg::FRACTION_BITS);
        if (i_drive <= $signed(DRIVE_W'(0))) begin
            level = '0;
        end else if (shifted > $signed(DRIVE_W'(LEVEL_MAX))) begin
            level = LEVEL_W'(LEVEL_MAX);
        end else begin
            level = shifted[LEVEL_W-1:0];
        end

        quarter = QUART_W'(level >> 2);
        if (quarter > QUART_W'(pidh_pkg::DUTY_MAX)) begin
            o_duty = pidh_pkg::DUTY_MAX;
        end else begin
            o_duty = quarter[DUTY_W-1:0];
        end

        // relay stays off (compare at ceiling) when the duty is zero
        if (o_duty != '0) begin
            o_pwm_compare = pidh_pkg::DUTY_MAX - o_duty;
        end else begin
            o_pwm_compare = pidh_pkg::DUTY_MAX;
        end
    end

endmodule

// ===== rtl/pid_heater_duty_controller_top.sv =====
// ============================================================================
// pid_heater_duty_controller_top: fixed-point PID heater controller
// Temperature samples in, heater duty and relay PWM compare out.
// ============================================================================
// Usage:
//   Slave stream: one transfer per control tick. tdata carries the signed
//   Q8.8 temperature, tuser carries the op (tick or clear). A clear zeroes
//   the error sum and the previous sample and yields duty 0, compare 255.
//   Master stream: one transfer per input transfer, in order. tdata carries
//   duty in the low byte and the relay compare in the high byte.
//   Configuration: write setpoint, gains and windup limit through the plain
//   write port while no item is in flight; out-of-range indexes are dropped.
// Timing:
//   Three register stages (state update, product registers, output
//   register). One item is taken every cycle while the receiver does not
//   stall. The error sum closes its loop within the first stage, so
//   ticks may follow each other back to back.
// Reset and stall:
//   Synchronous active-low reset clears the sum, the previous sample, all
//   stage valids and the configuration registers (windup limit to its
//   maximum). When the receiver stalls, each stage holds only while the
//   one after it is full; the pipeline keeps filling its empty stages before tready drops.
// ============================================================================
module pid_heater_duty_controller_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // slave stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [15:0]                         s_axis_tdata,  // [15:0] temperature
    input  logic                                s_axis_tuser,  // [0] op
    // master stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [15:0]                         m_axis_tdata,  // [7:0] duty, [15:8] pwm_compare
    // configuration write port
    input  logic                                i_cfg_we,
    input  logic [pidh_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pidh_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int TEMP_W    = pidh_pkg::TEMP_W;
    localparam int ERR_W     = pidh_pkg::ERR_W;
    localparam int SUM_W     = pidh_pkg::SUM_W;
    localparam int LIMIT_W   = pidh_pkg::LIMIT_W;
    localparam int PROD_PE_W = pidh_pkg::PROD_PE_W;
    localparam int PROD_I_W  = pidh_pkg::PROD_I_W;
    localparam int DRIVE_W   = pidh_pkg::DRIVE_W;
    localparam int DUTY_W    = pidh_pkg::DUTY_W;
    localparam int ACC_W     = SUM_W + 1;   // sum before the clamp

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [TEMP_W-1:0]  r_setpoint;
    logic signed [TEMP_W-1:0]  r_prop_gain;
    logic signed [TEMP_W-1:0]  r_integ_gain;
    logic signed [TEMP_W-1:0]  r_deriv_gain;
    logic        [LIMIT_W-1:0] r_windup_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint     <= '0;
            r_prop_gain    <= '0;
            r_integ_gain   <= '0;
            r_deriv_gain   <= '0;
            r_windup_limit <= pidh_pkg::WINDUP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pidh_pkg::REG_SETPOINT:   r_setpoint     <= i_cfg_wdata[TEMP_W-1:0];
                pidh_pkg::REG_PROP_GAIN:  r_prop_gain    <= i_cfg_wdata[TEMP_W-1:0];
                pidh_pkg::REG_INTEG_GAIN: r_integ_gain   <= i_cfg_wdata[TEMP_W-1:0];
                pidh_pkg::REG_DERIV_GAIN: r_deriv_gain   <= i_cfg_wdata[TEMP_W-1:0];
                pidh_pkg::REG_WINDUP:     r_windup_limit <= i_cfg_wdata;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when it is empty or drains
    // ------------------------------------------------------------------
    logic r1_valid, r2_valid, r3_valid;
    logic rdy1, rdy2, rdy3;
    logic in_xfer;

    assign rdy3          = !r3_valid || m_axis_tready;
    assign rdy2          = !r2_valid || rdy3;
    assign rdy1          = !r1_valid || rdy2;
    assign s_axis_tready = rdy1;
    assign in_xfer       = s_axis_tvalid && rdy1;

    // ------------------------------------------------------------------
    // Stage 1: error, clamped integral and sample change; state update
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0]  r_error_sum;
    logic signed [TEMP_W-1:0] r_prev_sample;
    logic signed [ERR_W-1:0]  r1_err;
    logic signed [SUM_W-1:0]  r1_sum;
    logic signed [ERR_W-1:0]  r1_diff;

    logic signed [TEMP_W-1:0] sample;
    logic signed [ERR_W-1:0]  err;
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  lim_pos;
    logic signed [ACC_W-1:0]  lim_neg;
    logic signed [SUM_W-1:0]  n_error_sum;
    logic signed [TEMP_W-1:0] n_prev_sample;
    logic signed [ERR_W-1:0]  n_err;
    logic signed [ERR_W-1:0]  n_diff;
    logic                     is_clear;

    always_comb begin
        sample   = s_axis_tdata;
        is_clear = (s_axis_tuser == pidh_pkg::OP_CLEAR);
        err      = ERR_W'(r_setpoint) - ERR_W'(sample);
        acc      = ACC_W'(r_error_sum) + ACC_W'(err);
        lim_pos  = $signed({{(ACC_W-LIMIT_W){1'b0}}, r_windup_limit});
        lim_neg  = -lim_pos;

        if (is_clear) begin
            // zero all operands so the drive comes out as zero
            n_error_sum   = '0;
            n_prev_sample = '0;
            n_err         = '0;
            n_diff        = '0;
        end else begin
            if (acc > lim_pos) begin
                n_error_sum = lim_pos[SUM_W-1:0];
            end else if (acc < lim_neg) begin
                n_error_sum = lim_neg[SUM_W-1:0];
            end else begin
                n_error_sum = acc[SUM_W-1:0];
            end
            n_prev_sample = sample;
            n_err         = err;
            n_diff        = ERR_W'(sample) - ERR_W'(r_prev_sample);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum   <= '0;
            r_prev_sample <= '0;
            r1_valid      <= 1'b0;
        end else if (rdy1) begin
            r1_valid <= s_axis_tvalid;
            if (s_axis_tvalid) begin
                r_error_sum   <= n_error_sum;
                r_prev_sample <= n_prev_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r1_err  <= n_err;
            r1_sum  <= n_error_sum;
            r1_diff <= n_diff;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: three independent products
    // ------------------------------------------------------------------
    logic signed [PROD_PE_W-1:0] r2_p;
    logic signed [PROD_I_W-1:0]  r2_i;
    logic signed [PROD_PE_W-1:0] r2_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (rdy2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r1_valid && rdy2) begin
            r2_p <= r_prop_gain  * r1_err;
            r2_i <= r_integ_gain * r1_sum;
            r2_d <= r_deriv_gain * r1_diff;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: drive sum, duty map and output register
    // ------------------------------------------------------------------
    logic signed [DRIVE_W-1:0] drive;
    logic        [DUTY_W-1:0]  duty;
    logic        [DUTY_W-1:0]  pwm_compare;
    logic        [DUTY_W-1:0]  r3_duty;
    logic        [DUTY_W-1:0]  r3_pwm_compare;

    assign drive = DRIVE_W'(r2_p) + DRIVE_W'(r2_i) - DRIVE_W'(r2_d);

    pidh_output_map u_output_map (
        .i_drive       (drive),
        .o_duty        (duty),
        .o_pwm_compare (pwm_compare)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (rdy3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r2_valid && rdy3) begin
            r3_duty        <= duty;
            r3_pwm_compare <= pwm_compare;
        end
    end

    assign m_axis_tvalid = r3_valid;
    assign m_axis_tdata  = {r3_pwm_compare, r3_duty};

endmodule
